[sv/debf_pkg.sv]
// Shared types, widths and constants for the dual envelope band follower.
// No dependencies; every other file of the block except debf_ram uses this package.
package debf_pkg;

   // Number of stored bands and the width of a store address.
   localparam int BANDS  = 32;
   localparam int ADDR_W = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int BCMP_W = 9;

   // Field widths.
   localparam int BAND_W = 5;
   localparam int Q_W    = 18;
   localparam int KO_W   = 36;
   localparam int IDX_W  = 3;

   // Datapath widths.
   localparam int TGT_W  = 17;
   localparam int SUM_W  = 19;
   localparam int HD_W   = 19;
   localparam int HM_W   = 18;
   localparam int SQ_W   = 35;
   localparam int A_W    = SQ_W - 16;
   localparam int AH_W   = 36;
   localparam int REL_W  = 37;
   localparam int SQP_W  = 54;
   localparam int CUB_W  = 55;
   localparam int S_W    = 30;
   localparam int MEM_W  = 2 * Q_W;

   // Q2.15 constants.
   localparam logic signed [Q_W-1:0]   Q_MINUS_ONE = -18'sd32768;
   localparam logic signed [Q_W-1:0]   Q_MIN       = -18'sd131072;
   localparam logic signed [Q_W-1:0]   Q_MAX       = 18'sd131071;
   localparam logic signed [SUM_W-1:0] TGT_LO      = -19'sd32768;
   localparam logic signed [SUM_W-1:0] TGT_HI      = 19'sd32768;

   // Register indexes.
   localparam logic [IDX_W-1:0] CSR_PRI_LIMIT = 3'd0;
   localparam logic [IDX_W-1:0] CSR_PRI_GAIN  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_PRI_COEF  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_PRI_KNEE  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_SEC_LIMIT = 3'd4;
   localparam logic [IDX_W-1:0] CSR_SEC_GAIN  = 3'd5;
   localparam logic [IDX_W-1:0] CSR_SEC_COEF  = 3'd6;
   localparam logic [IDX_W-1:0] CSR_SEC_KNEE  = 3'd7;

   typedef struct packed {
      logic signed [Q_W-1:0] limit;
      logic signed [Q_W-1:0] gain;
      logic signed [Q_W-1:0] coef;
      logic signed [Q_W-1:0] knee;
      logic signed [Q_W-1:0] offset;
   } plane_cfg_type;

   // Saturate a wide sum to the Q2.15 range.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [S_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v < S_W'(Q_MIN)) begin
         r = Q_MIN;
      end else if (v > S_W'(Q_MAX)) begin
         r = Q_MAX;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

[sv/debf_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module debf_ram #(
   parameter int WIDTH  = 36,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/dual_envelope_band_follower.sv]
// Top level of the dual envelope band follower: band maximum, target clamp and
// the two attack/release envelopes. Depends on debf_pkg and debf_ram.
//
//   Channel  Ports     Direction  Contents
//   req      req_*     in         band, level, last_channel, bias
//   rsp      rsp_*     out        out_band, rise, primary_level, secondary_level
//   csr      csr_*     in         register index (3 bits), write data (36 bits)
//
// An item without the last-channel mark only folds its level into the running
// maximum. A last-channel item runs through the states DIFF, SQR, PROD, CUBE and
// WB and leaves its result in the output register as WB ends; the next item can
// be taken once the sequencer is back in IDLE. The chain of three registered
// multiplies of the cube curve sets the length of that sequence. Both envelopes
// of a band share one RAM word, read when the item is accepted and written back
// in the final cycle. Reset is synchronous; 32 valid bits mark the RAM words that
// were written, and an unwritten word reads as minus one, so no clearing pass
// runs. If the output register still holds an untaken result, the write-back
// waits, and no new item is taken until it completes.
module dual_envelope_band_follower (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic        [debf_pkg::BAND_W-1:0]  req_band,
   input  logic signed [debf_pkg::Q_W-1:0]     req_level,
   input  logic                                req_last_channel,
   input  logic signed [debf_pkg::Q_W-1:0]     req_bias,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [debf_pkg::BAND_W-1:0]  rsp_out_band,
   output logic                                rsp_rise,
   output logic signed [debf_pkg::Q_W-1:0]     rsp_primary_level,
   output logic signed [debf_pkg::Q_W-1:0]     rsp_secondary_level,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [debf_pkg::IDX_W-1:0]   csr_index,
   input  logic        [debf_pkg::KO_W-1:0]    csr_data
);

   import debf_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIFF = 3'd1;
   localparam logic [2:0] ST_SQR  = 3'd2;
   localparam logic [2:0] ST_PROD = 3'd3;
   localparam logic [2:0] ST_CUBE = 3'd4;
   localparam logic [2:0] ST_WB   = 3'd5;

   // Control registers.
   logic [2:0]            state_ff, state_in;
   logic signed [Q_W-1:0] run_max_ff, run_max_in;
   logic [BANDS-1:0]      valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   plane_cfg_type         cfg_pri_ff, cfg_pri_in;
   plane_cfg_type         cfg_sec_ff, cfg_sec_in;

   // Payload registers.
   logic [ADDR_W-1:0]       band_ff, band_in;
   logic signed [TGT_W-1:0] target_ff, target_in;
   logic signed [Q_W-1:0]   prev_p_ff, prev_p_in;
   logic signed [Q_W-1:0]   prev_s_ff, prev_s_in;
   logic signed [HD_W-1:0]  hd_p_ff, hd_p_in;
   logic signed [HD_W-1:0]  hd_s_ff, hd_s_in;
   logic [SQ_W-1:0]         sq_p_ff, sq_p_in;
   logic [SQ_W-1:0]         sq_s_ff, sq_s_in;
   logic signed [REL_W-1:0] rel_p_ff, rel_p_in;
   logic signed [REL_W-1:0] rel_s_ff, rel_s_in;
   logic signed [SQP_W-1:0] curve_p_ff, curve_p_in;
   logic [AH_W-1:0]         ah_ff, ah_in;
   logic signed [CUB_W-1:0] curve_s_ff, curve_s_in;
   logic [BAND_W-1:0]       rsp_band_ff, rsp_band_in;
   logic                    rsp_rise_ff, rsp_rise_in;
   logic signed [Q_W-1:0]   rsp_pri_ff, rsp_pri_in;
   logic signed [Q_W-1:0]   rsp_sec_ff, rsp_sec_in;

   // Combinational helpers.
   logic                    req_accept;
   logic                    in_range;
   logic signed [Q_W-1:0]   lvl_max;
   logic signed [SUM_W-1:0] tgt_sum;
   logic signed [TGT_W-1:0] tgt_clamped;
   logic                    mem_rd_en;
   logic                    mem_wr_en;
   logic [MEM_W-1:0]        mem_rd_data;
   logic signed [Q_W-1:0]   stored_p;
   logic signed [Q_W-1:0]   stored_s;
   logic [2*HM_W-1:0]       sq_p_full;
   logic [2*HM_W-1:0]       sq_s_full;
   logic [A_W+HM_W-1:0]     ah_full;
   logic signed [Q_W-1:0]   new_p;
   logic signed [Q_W-1:0]   new_s;
   logic                    wb_go;

   // Next envelope value of one plane from the half delta, the stored value,
   // the release product and the curve term (already floored to 2^-16 units).
   function automatic logic signed [Q_W-1:0] env_next(
      input plane_cfg_type          c,
      input logic signed [HD_W-1:0] hd,
      input logic signed [Q_W-1:0]  prev,
      input logic signed [REL_W-1:0] rel,
      input logic signed [S_W-1:0]  curve
   );
      logic signed [REL_W-16:0] step;
      logic signed [HD_W-1:0]   lim;
      logic signed [HD_W-1:0]   knee2;
      logic signed [HD_W-1:0]   off2;
      logic signed [S_W-1:0]    s;
      step  = rel[REL_W-1:15];
      lim   = $signed({c.limit, 1'b0});
      knee2 = $signed({c.knee, 1'b0});
      off2  = $signed({c.offset, 1'b0});
      if (hd < 0) begin
         // Release: gain on the negative half delta, bounded from below.
         if (step < (REL_W-15)'(lim)) begin
            step = (REL_W-15)'(lim);
         end
         s = S_W'(step) + S_W'(prev);
      end else if (knee2 < hd) begin
         // Above the knee the envelope jumps by the offset plus the delta.
         s = S_W'(off2) + S_W'(hd) + S_W'(prev);
      end else begin
         s = curve + S_W'(prev);
      end
      return sat_q(s);
   endfunction

   assign req_accept = req_valid && req_ready;
   assign in_range   = BCMP_W'(req_band) < BCMP_W'(BANDS);
   assign lvl_max    = (req_level > run_max_ff) ? req_level : run_max_ff;
   assign tgt_sum    = SUM_W'(lvl_max) + SUM_W'(req_bias);

   always_comb begin
      if (tgt_sum < TGT_LO) begin
         tgt_clamped = TGT_LO[TGT_W-1:0];
      end else if (tgt_sum > TGT_HI) begin
         tgt_clamped = TGT_HI[TGT_W-1:0];
      end else begin
         tgt_clamped = tgt_sum[TGT_W-1:0];
      end
   end

   // The store read is launched on the accepting edge so that the data is
   // there in the first work cycle.
   assign mem_rd_en = req_accept && in_range && req_last_channel;

   // Words never written since reset read as minus one.
   assign stored_p = valid_ff[band_ff] ? $signed(mem_rd_data[MEM_W-1:Q_W]) : Q_MINUS_ONE;
   assign stored_s = valid_ff[band_ff] ? $signed(mem_rd_data[Q_W-1:0]) : Q_MINUS_ONE;

   // Squares of the half delta; they only matter when the delta is not
   // negative, where it stays below 2^18 and its square below 2^35.
   assign sq_p_full = hd_p_ff[HM_W-1:0] * hd_p_ff[HM_W-1:0];
   assign sq_s_full = hd_s_ff[HM_W-1:0] * hd_s_ff[HM_W-1:0];
   assign ah_full   = sq_s_ff[SQ_W-1:16] * hd_s_ff[HM_W-1:0];

   assign new_p = env_next(cfg_pri_ff, hd_p_ff, prev_p_ff, rel_p_ff,
                           S_W'($signed(curve_p_ff[SQP_W-1:27])));
   assign new_s = env_next(cfg_sec_ff, hd_s_ff, prev_s_ff, rel_s_ff,
                           S_W'($signed(curve_s_ff[CUB_W-1:26])));

   // Write-back goes ahead once the output register is free or being emptied.
   assign wb_go     = (state_ff == ST_WB) && (!rsp_valid_ff || rsp_ready);
   assign mem_wr_en = wb_go;

   debf_ram #(
      .WIDTH  (MEM_W),
      .DEPTH  (BANDS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (band_ff),
      .wr_data ({new_p, new_s}),
      .rd_en   (mem_rd_en),
      .rd_addr (req_band[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   // Configuration writes.
   always_comb begin
      cfg_pri_in = cfg_pri_ff;
      cfg_sec_in = cfg_sec_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRI_LIMIT: cfg_pri_in.limit = $signed(csr_data[Q_W-1:0]);
            CSR_PRI_GAIN:  cfg_pri_in.gain  = $signed(csr_data[Q_W-1:0]);
            CSR_PRI_COEF:  cfg_pri_in.coef  = $signed(csr_data[Q_W-1:0]);
            CSR_PRI_KNEE: begin
               cfg_pri_in.knee   = $signed(csr_data[KO_W-1:Q_W]);
               cfg_pri_in.offset = $signed(csr_data[Q_W-1:0]);
            end
            CSR_SEC_LIMIT: cfg_sec_in.limit = $signed(csr_data[Q_W-1:0]);
            CSR_SEC_GAIN:  cfg_sec_in.gain  = $signed(csr_data[Q_W-1:0]);
            CSR_SEC_COEF:  cfg_sec_in.coef  = $signed(csr_data[Q_W-1:0]);
            CSR_SEC_KNEE: begin
               cfg_sec_in.knee   = $signed(csr_data[KO_W-1:Q_W]);
               cfg_sec_in.offset = $signed(csr_data[Q_W-1:0]);
            end
            default: begin
               cfg_pri_in = cfg_pri_ff;
               cfg_sec_in = cfg_sec_ff;
            end
         endcase
      end
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      run_max_in   = run_max_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      band_in      = band_ff;
      target_in    = target_ff;
      prev_p_in    = prev_p_ff;
      prev_s_in    = prev_s_ff;
      hd_p_in      = hd_p_ff;
      hd_s_in      = hd_s_ff;
      sq_p_in      = sq_p_ff;
      sq_s_in      = sq_s_ff;
      rel_p_in     = rel_p_ff;
      rel_s_in     = rel_s_ff;
      curve_p_in   = curve_p_ff;
      ah_in        = ah_ff;
      curve_s_in   = curve_s_ff;
      rsp_band_in  = rsp_band_ff;
      rsp_rise_in  = rsp_rise_ff;
      rsp_pri_in   = rsp_pri_ff;
      rsp_sec_in   = rsp_sec_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && in_range) begin
               if (req_last_channel) begin
                  // The band closes: the maximum starts over at minus one.
                  run_max_in = Q_MINUS_ONE;
                  band_in    = req_band[ADDR_W-1:0];
                  target_in  = tgt_clamped;
                  state_in   = ST_DIFF;
               end else begin
                  run_max_in = lvl_max;
               end
            end
         end
         ST_DIFF: begin
            prev_p_in = stored_p;
            prev_s_in = stored_s;
            hd_p_in   = HD_W'(target_ff) - HD_W'(stored_p);
            hd_s_in   = HD_W'(target_ff) - HD_W'(stored_s);
            state_in  = ST_SQR;
         end
         ST_SQR: begin
            sq_p_in  = sq_p_full[SQ_W-1:0];
            sq_s_in  = sq_s_full[SQ_W-1:0];
            rel_p_in = cfg_pri_ff.gain * hd_p_ff;
            rel_s_in = cfg_sec_ff.gain * hd_s_ff;
            state_in = ST_PROD;
         end
         ST_PROD: begin
            curve_p_in = $signed({1'b0, sq_p_ff}) * cfg_pri_ff.coef;
            ah_in      = ah_full[AH_W-1:0];
            state_in   = ST_CUBE;
         end
         ST_CUBE: begin
            curve_s_in = $signed({1'b0, ah_ff}) * cfg_sec_ff.coef;
            state_in   = ST_WB;
         end
         ST_WB: begin
            if (wb_go) begin
               valid_in[band_ff] = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_band_in       = BAND_W'(band_ff);
               rsp_rise_in       = prev_p_ff < target_ff;
               rsp_pri_in        = new_p;
               rsp_sec_in        = new_s;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_max_ff   <= Q_MINUS_ONE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_pri_ff   <= '0;
         cfg_sec_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         run_max_ff   <= run_max_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_pri_ff   <= cfg_pri_in;
         cfg_sec_ff   <= cfg_sec_in;
      end
   end

   always_ff @(posedge clock) begin
      band_ff     <= band_in;
      target_ff   <= target_in;
      prev_p_ff   <= prev_p_in;
      prev_s_ff   <= prev_s_in;
      hd_p_ff     <= hd_p_in;
      hd_s_ff     <= hd_s_in;
      sq_p_ff     <= sq_p_in;
      sq_s_ff     <= sq_s_in;
      rel_p_ff    <= rel_p_in;
      rel_s_ff    <= rel_s_in;
      curve_p_ff  <= curve_p_in;
      ah_ff       <= ah_in;
      curve_s_ff  <= curve_s_in;
      rsp_band_ff <= rsp_band_in;
      rsp_rise_ff <= rsp_rise_in;
      rsp_pri_ff  <= rsp_pri_in;
      rsp_sec_ff  <= rsp_sec_in;
   end

   // A new item is taken only while no band is in flight.
   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_band        = rsp_band_ff;
   assign rsp_rise            = rsp_rise_ff;
   assign rsp_primary_level   = rsp_pri_ff;
   assign rsp_secondary_level = rsp_sec_ff;

endmodule

[sv/debf_checker.sv]
// Port-level checks for the dual envelope band follower, bound to the top level.
// Depends on debf_pkg and dual_envelope_band_follower.
module debf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_last_channel,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic        [debf_pkg::BAND_W-1:0]  rsp_out_band,
   input logic                                rsp_rise,
   input logic signed [debf_pkg::Q_W-1:0]     rsp_primary_level,
   input logic signed [debf_pkg::Q_W-1:0]     rsp_secondary_level
);

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_band) && $stable(rsp_rise)
         && $stable(rsp_primary_level) && $stable(rsp_secondary_level))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // An item that does not close a band never yields a result.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_channel && !rsp_valid |=> !rsp_valid)
      else $error("result after an item without the last-channel mark");

   // Closing a band occupies the block for the following cycle.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_channel |=> !req_ready)
      else $error("item taken while a band is in flight");

endmodule

bind dual_envelope_band_follower debf_checker u_debf_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for dual_envelope_band_follower, with a built-in predictor
// of the band maximum, target clamp and both envelopes. Depends on debf_pkg and the RTL.
module tb;
   import debf_pkg::*;

   // One level item as it goes into the block, and one result item as it comes out.
   typedef struct {
      logic [BAND_W-1:0]     band;
      logic signed [Q_W-1:0] level;
      logic                  last_channel;
      logic signed [Q_W-1:0] bias;
   } level_item_type;

   typedef struct {
      logic [BAND_W-1:0]     band;
      logic                  rise;
      logic signed [Q_W-1:0] primary;
      logic signed [Q_W-1:0] secondary;
   } envelope_type;

   // Quiet cycles after the drain, enough to let a trailing item without the
   // last-channel mark settle as well.
   localparam int SETTLE_CYCLES = 16;
   // Length of the long receiver hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES   = 300;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [BAND_W-1:0]     req_band         = '0;
   logic signed [Q_W-1:0] req_level        = '0;
   logic                  req_last_channel = 1'b0;
   logic signed [Q_W-1:0] req_bias         = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [BAND_W-1:0]     rsp_out_band;
   logic                  rsp_rise;
   logic signed [Q_W-1:0] rsp_primary_level;
   logic signed [Q_W-1:0] rsp_secondary_level;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic [IDX_W-1:0]      csr_index        = '0;
   logic [KO_W-1:0]       csr_data         = '0;

   // Items waiting to be offered, and results the predictor has already worked out.
   level_item_type level_queue[$];
   envelope_type   expected_env[$];
   int             mismatches = 0;

   // Idle and stall chances in percent, changed between phases on the falling edge.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // Long hold-off of the receiver, armed once by the stimulus and counted down below.
   bit hold_request = 1'b0;
   bit hold_used    = 1'b0;
   int hold_left    = 0;

   // Predictor state: its own copy of the registers, the band maximum and both stores.
   plane_cfg_type         pri_mirror = '0;
   plane_cfg_type         sec_mirror = '0;
   logic signed [Q_W-1:0] band_peak  = Q_MINUS_ONE;
   logic signed [Q_W-1:0] primary_env[BANDS];
   logic signed [Q_W-1:0] secondary_env[BANDS];

   initial begin
      for (int i = 0; i < BANDS; i++) begin
         primary_env[i]   = Q_MINUS_ONE;
         secondary_env[i] = Q_MINUS_ONE;
      end
   end

   dual_envelope_band_follower uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_band            (req_band),
      .req_level           (req_level),
      .req_last_channel    (req_last_channel),
      .req_bias            (req_bias),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_band        (rsp_out_band),
      .rsp_rise            (rsp_rise),
      .rsp_primary_level   (rsp_primary_level),
      .rsp_secondary_level (rsp_secondary_level),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // One attack/release step of an envelope. All arithmetic runs in 64 bits, where
   // prev and the half delta are both read in units of 2^-16, and every right shift
   // of a signed value floors toward minus infinity.
   function automatic logic signed [Q_W-1:0] follow_envelope(input plane_cfg_type c,
         input logic signed [Q_W-1:0] prev, input longint target, input bit cube_curve);
      longint hd, step, sq, s, lim, gain, coef, knee, offs;
      lim  = $signed(c.limit);
      gain = $signed(c.gain);
      coef = $signed(c.coef);
      knee = $signed(c.knee);
      offs = $signed(c.offset);
      hd   = target - prev;
      if (hd < 0) begin
         // Release: the scaled step may not fall below the limit.
         step = (gain * hd) >>> 15;
         if (step < 2 * lim) begin
            step = 2 * lim;
         end
         s = step + prev;
      end else if (2 * knee < hd) begin
         // Above the knee the envelope jumps by the delta plus the offset.
         s = 2 * offs + hd + prev;
      end else if (!cube_curve) begin
         s = ((hd * hd * coef) >>> 27) + prev;
      end else begin
         // The cube curve floors the square first, then floors again at the end.
         sq = (hd * hd) >>> 16;
         s  = ((sq * hd * coef) >>> 26) + prev;
      end
      if (s < Q_MIN) begin
         return Q_MIN;
      end else if (s > Q_MAX) begin
         return Q_MAX;
      end
      return Q_W'(s);
   endfunction

   // Fold one accepted item into the predictor. An item with the last-channel mark
   // closes the band: the band of that item picks the stores, whatever the bands of
   // the items before it were, and the maximum starts again from minus one.
   function automatic void fold_level(input level_item_type it);
      logic signed [Q_W-1:0] peak;
      longint                target;
      envelope_type          res;
      if (it.band >= BANDS) begin
         return;
      end
      peak = (it.level > band_peak) ? it.level : band_peak;
      if (!it.last_channel) begin
         band_peak = peak;
         return;
      end
      band_peak = Q_MINUS_ONE;
      target    = peak;
      target    = target + it.bias;
      if (target < TGT_LO) begin
         target = TGT_LO;
      end else if (target > TGT_HI) begin
         target = TGT_HI;
      end
      res.band      = it.band;
      res.rise      = primary_env[it.band] < target;
      res.primary   = follow_envelope(pri_mirror, primary_env[it.band], target, 1'b0);
      res.secondary = follow_envelope(sec_mirror, secondary_env[it.band], target, 1'b1);
      primary_env[it.band]   = res.primary;
      secondary_env[it.band] = res.secondary;
      expected_env.push_back(res);
   endfunction

   function automatic void check_envelope(input envelope_type got);
      envelope_type want;
      if (expected_env.size() == 0) begin
         $error("result for band %0d arrived with nothing expected", got.band);
         mismatches++;
         return;
      end
      want = expected_env.pop_front();
      if (got.band !== want.band) begin
         $error("rsp_out_band: expected %0d, got %0d", want.band, got.band);
         mismatches++;
      end
      if (got.rise !== want.rise) begin
         $error("rsp_rise: expected %0d, got %0d", want.rise, got.rise);
         mismatches++;
      end
      if (got.primary !== want.primary) begin
         $error("rsp_primary_level: expected %0d, got %0d", want.primary, got.primary);
         mismatches++;
      end
      if (got.secondary !== want.secondary) begin
         $error("rsp_secondary_level: expected %0d, got %0d", want.secondary,
                got.secondary);
         mismatches++;
      end
   endfunction

   // Driver. The item on the port is predicted at the edge that accepts it; a new
   // item (or an idle cycle) is put up only when the port is free, so valid and the
   // payload never move while an item is waiting.
   always @(posedge clock) begin : drive_levels
      level_item_type taken;
      level_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken.band         = req_band;
            taken.level        = req_level;
            taken.last_channel = req_last_channel;
            taken.bias         = req_bias;
            fold_level(taken);
         end
         if (!req_valid || req_ready) begin
            if (level_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_item = level_queue.pop_front();
               req_valid        <= 1'b1;
               req_band         <= next_item.band;
               req_level        <= next_item.level;
               req_last_channel <= next_item.last_channel;
               req_bias         <= next_item.bias;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The long hold-off runs once, as soon as the stimulus asks for it.
   always @(posedge clock) begin
      if (hold_request && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor. Ready is redrawn every cycle; a result counts at the edge where it meets
   // the ready that was already on the port.
   always @(posedge clock) begin : watch_results
      envelope_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got.band      = rsp_out_band;
         got.rise      = rsp_rise;
         got.primary   = rsp_primary_level;
         got.secondary = rsp_secondary_level;
         check_envelope(got);
      end
   end

   function automatic void push_level(input int band, input int level, input bit last,
                                      input int bias);
      level_item_type it;
      it.band         = BAND_W'(band);
      it.level        = Q_W'(level);
      it.last_channel = last;
      it.bias         = Q_W'(bias);
      level_queue.push_back(it);
   endfunction

   function automatic int rand_full();
      return int'($signed(Q_W'($urandom)));
   endfunction

   // Levels mostly sit around the clamp window so that the envelopes travel in both
   // directions; the rest are the rails of the format or anything at all.
   function automatic int rand_level();
      case ($urandom_range(0, 9))
         0: return rand_full();
         1: begin
            case ($urandom_range(0, 3))
               0: return -131072;
               1: return 131071;
               2: return -32768;
               default: return 32768;
            endcase
         end
         default: return int'($urandom_range(0, 80000)) - 40000;
      endcase
   endfunction

   function automatic int rand_bias();
      case ($urandom_range(0, 9))
         0, 1, 2: return 0;
         3: return rand_full();
         default: return int'($urandom_range(0, 16000)) - 8000;
      endcase
   endfunction

   // Mostly a complete band: one to four channels, the last one marked. Now and then
   // a stray item with any band and a random mark, which also mixes bands within a
   // running maximum.
   function automatic int add_band_group();
      int b;
      int n;
      if ($urandom_range(0, 99) < 15) begin
         push_level($urandom_range(0, 31), rand_full(), $urandom_range(0, 2) == 0,
                    rand_full());
         return 1;
      end
      b = $urandom_range(0, BANDS - 1);
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
         push_level(b, rand_level(), k == n - 1, rand_bias());
      end
      return n;
   endfunction

   function automatic plane_cfg_type rand_plane(input bit moderate);
      plane_cfg_type c;
      if (moderate) begin
         c.limit  = Q_W'(-int'($urandom_range(0, 8000)));
         c.gain   = Q_W'($urandom_range(0, 40000));
         c.coef   = Q_W'(int'($urandom_range(0, 131071)) - 65536);
         c.knee   = Q_W'($urandom_range(0, 20000));
         c.offset = Q_W'(int'($urandom_range(0, 4000)) - 2000);
      end else begin
         c.limit  = Q_W'($urandom);
         c.gain   = Q_W'($urandom);
         c.coef   = Q_W'($urandom);
         c.knee   = Q_W'($urandom);
         c.offset = Q_W'($urandom);
      end
      return c;
   endfunction

   // Called on a rising edge with the block idle. Valid stays up from one register
   // to the next; the caller lowers it after the last one.
   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [KO_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         CSR_PRI_LIMIT: pri_mirror.limit = data[Q_W-1:0];
         CSR_PRI_GAIN:  pri_mirror.gain  = data[Q_W-1:0];
         CSR_PRI_COEF:  pri_mirror.coef  = data[Q_W-1:0];
         CSR_PRI_KNEE: begin
            pri_mirror.knee   = data[KO_W-1:Q_W];
            pri_mirror.offset = data[Q_W-1:0];
         end
         CSR_SEC_LIMIT: sec_mirror.limit = data[Q_W-1:0];
         CSR_SEC_GAIN:  sec_mirror.gain  = data[Q_W-1:0];
         CSR_SEC_COEF:  sec_mirror.coef  = data[Q_W-1:0];
         CSR_SEC_KNEE: begin
            sec_mirror.knee   = data[KO_W-1:Q_W];
            sec_mirror.offset = data[Q_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // The upper half of an 18-bit register write carries random bits, which the
   // block has to ignore.
   task automatic set_config(input plane_cfg_type pri, input plane_cfg_type sec);
      write_csr(CSR_PRI_LIMIT, {Q_W'($urandom), pri.limit});
      write_csr(CSR_PRI_GAIN,  {Q_W'($urandom), pri.gain});
      write_csr(CSR_PRI_COEF,  {Q_W'($urandom), pri.coef});
      write_csr(CSR_PRI_KNEE,  {pri.knee, pri.offset});
      write_csr(CSR_SEC_LIMIT, {Q_W'($urandom), sec.limit});
      write_csr(CSR_SEC_GAIN,  {Q_W'($urandom), sec.gain});
      write_csr(CSR_SEC_COEF,  {Q_W'($urandom), sec.coef});
      write_csr(CSR_SEC_KNEE,  {sec.knee, sec.offset});
      csr_valid <= 1'b0;
   endtask

   // One phase: set the idle pattern, queue the items, then wait until every item is
   // in and every result is out, plus a few quiet cycles. The drain is checked on the
   // falling edge, where the driver and the monitor have settled. Ends on a rising edge.
   task automatic run_phase(input int send_pct, input int stall_pct, input int n_random,
                            input bit directed, input bit long_hold);
      int added;
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      if (directed) begin
         // Level at the top rail, clamped to one: a rise from the reset envelope.
         push_level(0, 131071, 1'b1, 0);
         // Both rails at the bottom: the target clamps to minus one.
         push_level(0, -131072, 1'b1, -131072);
         // Three channels of the top band; the largest bias pushes past the clamp.
         push_level(31, 0, 1'b0, 0);
         push_level(31, 16384, 1'b0, -131072);
         push_level(31, -5, 1'b1, 131071);
         // A level below minus one leaves the maximum at its starting value.
         push_level(5, -131072, 1'b1, 131071);
         // Mixed bands: the maximum comes from band 3, the result goes to band 7.
         push_level(3, 20000, 1'b0, 0);
         push_level(7, -100, 1'b1, -3000);
         push_level(7, 0, 1'b1, 0);
         // The same target twice: the second gives no rise and a zero delta.
         push_level(10, 100, 1'b1, -1);
         push_level(10, 100, 1'b1, -1);
         // A fall back to minus one, then channels that never beat the maximum.
         push_level(10, -32768, 1'b1, 0);
         push_level(12, -40000, 1'b0, 0);
         push_level(12, -131072, 1'b0, 0);
         push_level(12, -32769, 1'b1, -1);
         // Small steps around zero in both directions.
         push_level(20, 1, 1'b1, 0);
         push_level(20, -1, 1'b1, 0);
         push_level(20, 32767, 1'b0, 0);
         push_level(20, -32768, 1'b1, 1);
         // An item without a mark sets the maximum for the marked item after it.
         push_level(31, 131071, 1'b1, -65536);
         push_level(15, 131071, 1'b0, 0);
         push_level(15, -20000, 1'b1, -131072);
      end
      added = 0;
      while (added < n_random) begin
         added += add_band_group();
      end
      if (long_hold) begin
         hold_request = 1'b1;
      end
      @(negedge clock);
      while (level_queue.size() != 0 || req_valid || expected_env.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      plane_cfg_type pri;
      plane_cfg_type sec;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the registers, directed items, no idling.
      run_phase(0, 0, 0, 1'b1, 1'b0);

      // A plausible setting: half-speed release, unit curve, a knee well inside range.
      pri = '{limit: -18'sd4000, gain: 18'sd16384, coef: 18'sd32768,
              knee: 18'sd8192, offset: 18'sd1000};
      sec = '{limit: -18'sd2000, gain: 18'sd8192, coef: 18'sd65536,
              knee: 18'sd16384, offset: -18'sd500};
      set_config(pri, sec);
      run_phase(0, 0, 350, 1'b0, 1'b0);

      // Every register at its top value: the curves saturate upward.
      pri = '{limit: Q_MAX, gain: Q_MAX, coef: Q_MAX, knee: Q_MAX, offset: Q_MAX};
      set_config(pri, pri);
      run_phase(61, 0, 250, 1'b0, 1'b0);

      // Every register at its bottom value: the knee path and negative saturation.
      pri = '{limit: Q_MIN, gain: Q_MIN, coef: Q_MIN, knee: Q_MIN, offset: Q_MIN};
      set_config(pri, pri);
      run_phase(0, 61, 250, 1'b0, 1'b0);

      set_config(rand_plane(1'b0), rand_plane(1'b0));
      run_phase(13, 13, 300, 1'b0, 1'b0);

      // Receiver holds off for a long stretch while the sender keeps offering.
      set_config(rand_plane(1'b1), rand_plane(1'b1));
      run_phase(0, 0, 300, 1'b0, 1'b1);

      set_config(rand_plane(1'b1), rand_plane(1'b0));
      run_phase(13, 13, 400, 1'b0, 1'b0);

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
